@@ design/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg - shared definitions for the extent slice splitter
// Field widths, table limits, result status codes, register indexes and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

    // field widths
    localparam int FID_W   = 31;
    localparam int POS_W   = 48;
    localparam int LEN_W   = 40;
    localparam int SLOT_W  = 16;
    localparam int CNT_W   = 17;
    localparam int SHIFT_W = 6;
    localparam int CFG_W   = 17;
    localparam int EPOS_W  = POS_W + 1;   // position plus length needs one more bit

    // table and splitting limits
    localparam int TABLE_DEPTH = 65536;
    localparam int MAX_PIECES  = 64;
    localparam int PIECE_W     = $clog2(MAX_PIECES);

    // table depth clipped to what the entry count can express
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] DEPTH_CLIP =
        CNT_W'((TABLE_DEPTH > CNT_MAX) ? CNT_MAX : TABLE_DEPTH);

    // result status codes
    localparam logic [1:0] STAT_APPEND   = 2'd0;
    localparam logic [1:0] STAT_MERGE    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_TOO_MANY = 2'd3;

    // configuration register indexes
    localparam logic CFG_SLICE_SHIFT = 1'b0;
    localparam logic CFG_MAX_ENTRIES = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input extent
        logic calc1;    // slice numbers and tail match flags
        logic calc2;    // piece count and first boundary
        logic check;    // first piece length, piece counter
        logic emit;     // issue one piece
        logic reject;   // issue the reject result
    } esc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reject;      // extent fails the count or capacity check
        logic piece_last;  // current piece is the final one
        logic out_free;    // output register can take a result this cycle
    } esc_sts_t;

endpackage

@@ design/esc_ctrl.sv @@
// ----------------------------------------------------------------------------
// esc_ctrl - sequencer for the extent slice splitter
// Steps each extent through setup, then one piece per free output slot, or one reject result.
// ----------------------------------------------------------------------------
module esc_ctrl
    import esc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  esc_sts_t sts,
    output esc_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CALC1  = 6'b000010,
        S_CALC2  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_EMIT   = 6'b010000,
        S_REJECT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CALC1;
            end
            S_CALC1:  state_next = S_CALC2;
            S_CALC2:  state_next = S_CHECK;
            S_CHECK:  state_next = sts.reject ? S_REJECT : S_EMIT;
            S_EMIT:
            begin
                if (sts.out_free && sts.piece_last)
                    state_next = S_IDLE;
            end
            S_REJECT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // commands
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.calc1  = (state_reg == S_CALC1);
    assign cmd.calc2  = (state_reg == S_CALC2);
    assign cmd.check  = (state_reg == S_CHECK);
    assign cmd.emit   = (state_reg == S_EMIT) && sts.out_free;
    assign cmd.reject = (state_reg == S_REJECT) && sts.out_free;

endmodule

@@ design/esc_datapath.sv @@
// ----------------------------------------------------------------------------
// esc_datapath - slice arithmetic, index tail and result register
// Holds the configuration, the entry count and tail entry, works out the
// pieces of an extent one at a time and drives the output register.
// ----------------------------------------------------------------------------
module esc_datapath
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  esc_cmd_t           cmd,
    output esc_sts_t           sts,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // input extent
    input  logic [FID_W-1:0]   gfid,
    input  logic [POS_W-1:0]   byte_pos,
    input  logic [POS_W-1:0]   mem_pos,
    input  logic [LEN_W-1:0]   length,
    // result
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SLOT_W-1:0]  slot,
    output logic [FID_W-1:0]   entry_fid,
    output logic [POS_W-1:0]   entry_file_pos,
    output logic [POS_W-1:0]   entry_mem_pos,
    output logic [LEN_W-1:0]   entry_length,
    output logic [1:0]         status,
    output logic               last
);

    // configuration
    logic [SHIFT_W-1:0] slice_shift_reg;
    logic [CNT_W-1:0]   max_entries_reg;

    // table state
    logic [CNT_W-1:0]   count_reg;
    logic [FID_W-1:0]   tail_fid_reg;
    logic [POS_W-1:0]   tail_fp_reg;
    logic [POS_W-1:0]   tail_mp_reg;
    logic [LEN_W-1:0]   tail_len_reg;

    // captured extent
    logic [FID_W-1:0]   in_fid_reg;
    logic [POS_W-1:0]   in_pos_reg;
    logic [POS_W-1:0]   in_mem_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic [EPOS_W-1:0]  end_reg;

    // setup results
    logic [POS_W-1:0]   first_reg;
    logic [EPOS_W-1:0]  lastsl_reg;
    logic               same_slice_reg;
    logic               end_match_reg;
    logic [EPOS_W-1:0]  diff_reg;
    logic [EPOS_W-1:0]  boundary_reg;
    logic [EPOS_W-1:0]  slice_reg;

    // piece walk
    logic [EPOS_W-1:0]  cur_start_reg;
    logic [POS_W-1:0]   cur_mem_reg;
    logic [LEN_W-1:0]   plen_reg;
    logic [PIECE_W-1:0] rem_reg;
    logic               first_piece_reg;

    // output register
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FID_W-1:0]   fid_reg;
    logic [POS_W-1:0]   fp_reg;
    logic [POS_W-1:0]   mp_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    // combinational terms
    logic [CNT_W-1:0]   limit;
    logic               too_many;
    logic [CNT_W:0]     need;
    logic               full;
    logic [EPOS_W-1:0]  end_m1;
    logic [LEN_W:0]     len_sum;
    logic               merge;
    logic [CNT_W-1:0]   count_m1;
    logic [EPOS_W-1:0]  stop0;
    logic [EPOS_W-1:0]  plen0_full;
    logic [EPOS_W-1:0]  last_len_full;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_shift_reg <= SHIFT_W'(20);
            max_entries_reg <= CNT_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLICE_SHIFT: slice_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // count and capacity checks on the piece count
    assign limit    = (max_entries_reg < DEPTH_CLIP) ? max_entries_reg : DEPTH_CLIP;
    assign too_many = (diff_reg > EPOS_W'(MAX_PIECES - 1));
    assign need     = {1'b0, count_reg} + (CNT_W+1)'(diff_reg[PIECE_W-1:0])
                      + (CNT_W+1)'(1);
    assign full     = (need >= {1'b0, limit});

    assign sts.reject     = too_many || full;
    assign sts.piece_last = (rem_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // last byte of the extent; a zero length stays at its start
    assign end_m1 = (in_len_reg == '0) ? {1'b0, in_pos_reg} : (end_reg - EPOS_W'(1));

    // first-piece length ahead of the walk
    assign stop0      = (diff_reg == '0) ? end_reg : boundary_reg;
    assign plen0_full = stop0 - {1'b0, in_pos_reg};
    assign last_len_full = end_reg - boundary_reg;

    // coalescing into the tail entry
    assign len_sum  = {1'b0, tail_len_reg} + {1'b0, plen_reg};
    assign merge    = first_piece_reg && (count_reg != '0) && (tail_fid_reg == in_fid_reg)
                      && end_match_reg && same_slice_reg && !len_sum[LEN_W];
    assign count_m1 = count_reg - CNT_W'(1);

    // extent capture and setup steps; the slice boundary steps on per piece
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_fid_reg <= gfid;
            in_pos_reg <= byte_pos;
            in_mem_reg <= mem_pos;
            in_len_reg <= length;
            end_reg    <= {1'b0, byte_pos} + EPOS_W'(length);
        end
        if (cmd.calc1)
        begin
            first_reg      <= in_pos_reg >> slice_shift_reg;
            lastsl_reg     <= end_m1 >> slice_shift_reg;
            same_slice_reg <= ((tail_fp_reg >> slice_shift_reg) ==
                               (in_pos_reg >> slice_shift_reg));
            end_match_reg  <= (({1'b0, tail_fp_reg} + EPOS_W'(tail_len_reg)) ==
                               {1'b0, in_pos_reg});
        end
        if (cmd.calc2)
        begin
            diff_reg     <= lastsl_reg - {1'b0, first_reg};
            boundary_reg <= ({1'b0, first_reg} + EPOS_W'(1)) << slice_shift_reg;
            slice_reg    <= EPOS_W'(1) << slice_shift_reg;
        end
        else if (cmd.emit)
            boundary_reg <= boundary_reg + slice_reg;
    end

    // piece walk: one piece per emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_piece_reg <= 1'b0;
        else if (cmd.check)
            first_piece_reg <= 1'b1;
        else if (cmd.emit)
            first_piece_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            cur_start_reg <= {1'b0, in_pos_reg};
            cur_mem_reg   <= in_mem_reg;
            plen_reg      <= plen0_full[LEN_W-1:0];
            rem_reg       <= diff_reg[PIECE_W-1:0];
        end
        else if (cmd.emit)
        begin
            cur_start_reg <= boundary_reg;
            cur_mem_reg   <= cur_mem_reg + POS_W'(plen_reg);
            rem_reg       <= rem_reg - PIECE_W'(1);
            plen_reg      <= (rem_reg == PIECE_W'(1)) ? last_len_full[LEN_W-1:0]
                                                      : slice_reg[LEN_W-1:0];
        end
    end

    // entry count and tail entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            tail_fid_reg <= '0;
            tail_fp_reg  <= '0;
            tail_mp_reg  <= '0;
            tail_len_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (merge)
                tail_len_reg <= len_sum[LEN_W-1:0];
            else
            begin
                tail_fid_reg <= in_fid_reg;
                tail_fp_reg  <= cur_start_reg[POS_W-1:0];
                tail_mp_reg  <= cur_mem_reg;
                tail_len_reg <= plen_reg;
                count_reg    <= count_reg + CNT_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.reject)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.reject)
        begin
            slot_reg   <= count_reg[SLOT_W-1:0];
            fid_reg    <= in_fid_reg;
            fp_reg     <= in_pos_reg;
            mp_reg     <= in_mem_reg;
            len_reg    <= in_len_reg;
            status_reg <= too_many ? STAT_TOO_MANY : STAT_FULL;
            last_reg   <= 1'b1;
        end
        else if (cmd.emit)
        begin
            last_reg <= (rem_reg == '0);
            if (merge)
            begin
                slot_reg   <= count_m1[SLOT_W-1:0];
                fid_reg    <= tail_fid_reg;
                fp_reg     <= tail_fp_reg;
                mp_reg     <= tail_mp_reg;
                len_reg    <= len_sum[LEN_W-1:0];
                status_reg <= STAT_MERGE;
            end
            else
            begin
                slot_reg   <= count_reg[SLOT_W-1:0];
                fid_reg    <= in_fid_reg;
                fp_reg     <= cur_start_reg[POS_W-1:0];
                mp_reg     <= cur_mem_reg;
                len_reg    <= plen_reg;
                status_reg <= STAT_APPEND;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign entry_fid      = fid_reg;
    assign entry_file_pos = fp_reg;
    assign entry_mem_pos  = mp_reg;
    assign entry_length   = len_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

@@ design/extent_slice_split_and_coalesce.sv @@
// ----------------------------------------------------------------------------
// extent_slice_split_and_coalesce - write extent splitter and index coalescer
// Cuts a logged write extent at slice boundaries and turns the pieces into
// index-table appends, merging the first piece into the tail entry when it
// continues it.
// ----------------------------------------------------------------------------
// One extent is in flight at a time. After the input transfer the block steps
// through its setup states (slice numbers, piece count, capacity check and first
// piece length), then issues one result per cycle while the output register
// is free, stepping the piece sequencer once per result. An extent of n
// pieces (n = 1 for a reject) is finished, and the next input transfer can
// be taken, once its last result has entered the output register. The final
// result of an extent may still wait in the output register while the next
// extent is accepted.
module extent_slice_split_and_coalesce
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // input extent
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FID_W-1:0]   gfid,
    input  logic [POS_W-1:0]   byte_pos,
    input  logic [POS_W-1:0]   mem_pos,
    input  logic [LEN_W-1:0]   length,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SLOT_W-1:0]  slot,
    output logic [FID_W-1:0]   entry_fid,
    output logic [POS_W-1:0]   entry_file_pos,
    output logic [POS_W-1:0]   entry_mem_pos,
    output logic [LEN_W-1:0]   entry_length,
    output logic [1:0]         status,
    output logic               last
);

    esc_cmd_t cmd;
    esc_sts_t sts;

    // sequencer
    esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, table state and result register
    esc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .gfid           (gfid),
        .byte_pos       (byte_pos),
        .mem_pos        (mem_pos),
        .length         (length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .entry_fid      (entry_fid),
        .entry_file_pos (entry_file_pos),
        .entry_mem_pos  (entry_mem_pos),
        .entry_length   (entry_length),
        .status         (status),
        .last           (last)
    );

endmodule

@@ design/esc_checker.sv @@
// ----------------------------------------------------------------------------
// esc_checker - port-level checks for the extent slice splitter
// Watches the top-level ports and flags ordering and framing slips.
// ----------------------------------------------------------------------------
module esc_checker
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [LEN_W-1:0]   entry_length,
    input  logic [1:0]         status,
    input  logic               last
);

    // a stalled result holds its slot, length and framing
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(slot) && $stable(entry_length) && $stable(last))
        else $error("stalled result changed");

    // one extent at a time: no input transfer right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an extent is in flight");

    // a reject result is always marked last, as the only result of its extent
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL || status == STAT_TOO_MANY) |-> last)
        else $error("reject result not marked last");

    // while idle, only the final result of the previous extent can be pending
    a_idle_tail: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("idle with an unfinished extent in the output register");

endmodule

bind extent_slice_split_and_coalesce esc_checker u_esc_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the extent slice splitter and tail coalescer
// Offers logged write extents under random valid/ready pacing and checks
// every index-table write the block reports against a local prediction of
// the slice split, tail merge and capacity rules, over several register
// settings.
// ----------------------------------------------------------------------------
import esc_pkg::*;

localparam bit [63:0] LEN_MAX = (64'd1 << LEN_W) - 1;
localparam bit [63:0] POS_MAX = (64'd1 << POS_W) - 1;

// one write extent as offered on the input channel
typedef struct {
    logic [FID_W-1:0] gfid;
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] mem_pos;
    logic [LEN_W-1:0] length;
} extent_t;

// one index-table write as reported on the result channel
typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [FID_W-1:0]  fid;
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  mem_pos;
    logic [LEN_W-1:0]  length;
    logic [1:0]        status;
    logic              last;
} index_write_t;

// Index table scoreboard: tracks the table tail and count, predicts the
// writes caused by each extent and checks them in order.
class index_scoreboard;
    bit [SHIFT_W-1:0] slice_shift;
    bit [CFG_W-1:0]   max_entries;
    bit [CNT_W-1:0]   entry_count;
    bit [FID_W-1:0]   tail_fid;
    bit [POS_W-1:0]   tail_file_pos;
    bit [POS_W-1:0]   tail_mem_pos;
    bit [LEN_W-1:0]   tail_length;
    index_write_t     expected_writes[$];
    int unsigned      failures;

    function new();
        slice_shift   = SHIFT_W'(20);
        max_entries   = CFG_W'(65536);
        entry_count   = '0;
        tail_fid      = '0;
        tail_file_pos = '0;
        tail_mem_pos  = '0;
        tail_length   = '0;
        failures      = 0;
    endfunction

    function void set_register(logic reg_index, bit [CFG_W-1:0] value);
        if (reg_index == CFG_SLICE_SHIFT)
            slice_shift = value[SHIFT_W-1:0];
        else
            max_entries = value;
    endfunction

    function int pending();
        return expected_writes.size();
    endfunction

    function void push_write(bit [63:0] slot, bit [63:0] fid, bit [63:0] fpos,
                             bit [63:0] mpos, bit [63:0] len, bit [1:0] status,
                             bit last);
        index_write_t w;
        w.slot     = slot[SLOT_W-1:0];
        w.fid      = fid[FID_W-1:0];
        w.byte_pos = fpos[POS_W-1:0];
        w.mem_pos  = mpos[POS_W-1:0];
        w.length   = len[LEN_W-1:0];
        w.status   = status;
        w.last     = last;
        expected_writes.push_back(w);
    endfunction

    // split an accepted extent into pieces and update the table tail
    function void note_extent(extent_t x);
        bit [63:0] pos, mem, len, first_sl, last_sl, pieces, cap;
        bit [63:0] k, start, stop, plen, pmem;
        int        sh;
        bit        piece_last;
        pos = 64'(x.byte_pos);
        mem = 64'(x.mem_pos);
        len = 64'(x.length);
        sh  = int'(slice_shift);
        first_sl = pos >> sh;
        last_sl  = (len == 0) ? first_sl : ((pos + len - 1) >> sh);
        pieces   = last_sl - first_sl + 1;
        cap      = (64'(max_entries) < 64'(TABLE_DEPTH)) ? 64'(max_entries)
                                                         : 64'(TABLE_DEPTH);

        // rejects echo the extent at the next free slot
        if (pieces > 64'(MAX_PIECES))
        begin
            push_write(64'(entry_count), 64'(x.gfid), pos, mem, len, STAT_TOO_MANY, 1'b1);
            return;
        end
        if (64'(entry_count) + pieces >= cap)
        begin
            push_write(64'(entry_count), 64'(x.gfid), pos, mem, len, STAT_FULL, 1'b1);
            return;
        end

        for (k = 0; k < pieces; k++)
        begin
            start = (k == 0) ? pos : ((first_sl + k) << sh);
            stop  = (k == pieces - 1) ? (pos + len) : ((first_sl + k + 1) << sh);
            plen  = stop - start;
            pmem  = (mem + (start - pos)) & POS_MAX;
            piece_last = (k == pieces - 1);
            // first piece continuing the tail in the same slice is merged
            if (k == 0 && entry_count != 0 && tail_fid == x.gfid &&
                64'(tail_file_pos) + 64'(tail_length) == start &&
                (64'(tail_file_pos) >> sh) == (start >> sh) &&
                64'(tail_length) + plen <= LEN_MAX)
            begin
                tail_length = tail_length + plen[LEN_W-1:0];
                push_write(64'(entry_count - 1'b1), 64'(tail_fid), 64'(tail_file_pos),
                           64'(tail_mem_pos), 64'(tail_length), STAT_MERGE, piece_last);
            end
            else
            begin
                tail_fid      = x.gfid;
                tail_file_pos = start[POS_W-1:0];
                tail_mem_pos  = pmem[POS_W-1:0];
                tail_length   = plen[LEN_W-1:0];
                push_write(64'(entry_count), 64'(tail_fid), 64'(tail_file_pos),
                           64'(tail_mem_pos), 64'(tail_length), STAT_APPEND, piece_last);
                entry_count = entry_count + 1'b1;
            end
        end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    function void check_result(index_write_t got);
        index_write_t want;
        if (expected_writes.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual slot %0h status %0d",
                     $time, got.slot, got.status);
            failures++;
            return;
        end
        want = expected_writes.pop_front();
        check_field("slot", 64'(want.slot), 64'(got.slot));
        check_field("entry_fid", 64'(want.fid), 64'(got.fid));
        check_field("entry_file_pos", 64'(want.byte_pos), 64'(got.byte_pos));
        check_field("entry_mem_pos", 64'(want.mem_pos), 64'(got.mem_pos));
        check_field("entry_length", 64'(want.length), 64'(got.length));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("last", 64'(want.last), 64'(got.last));
    endfunction
endclass

module tb_top;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 40;
    localparam int RANDOM_PHASES  = 8;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [FID_W-1:0]   gfid;
    logic [POS_W-1:0]   byte_pos;
    logic [POS_W-1:0]   mem_pos;
    logic [LEN_W-1:0]   length;
    logic               out_valid;
    logic               out_ready;
    logic [SLOT_W-1:0]  slot;
    logic [FID_W-1:0]   entry_fid;
    logic [POS_W-1:0]   entry_file_pos;
    logic [POS_W-1:0]   entry_mem_pos;
    logic [LEN_W-1:0]   entry_length;
    logic [1:0]         status;
    logic               last;

    index_scoreboard sb = new();
    bit              no_idle = 1'b0;
    bit              hold_off_req = 1'b0;

    extent_slice_split_and_coalesce DUT (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: cycles without any transfer or register write
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // result monitor
    initial
    begin
        index_write_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen = '{slot, entry_fid, entry_file_pos, entry_mem_pos, entry_length,
                         status, last};
                sb.check_result(seen);
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready = no_idle || ($urandom_range(0, 99) >= 17);
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one extent and wait for its transfer; entered and left at negedge
    task automatic offer_extent(input bit [63:0] fid, input bit [63:0] fpos,
                                input bit [63:0] mpos, input bit [63:0] len);
        extent_t x;
        x.gfid     = fid[FID_W-1:0];
        x.byte_pos = fpos[POS_W-1:0];
        x.mem_pos  = mpos[POS_W-1:0];
        x.length   = len[LEN_W-1:0];
        while (!no_idle && $urandom_range(0, 99) < 17)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        gfid     = x.gfid;
        byte_pos = x.byte_pos;
        mem_pos  = x.mem_pos;
        length   = x.length;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_extent(x);
        @(negedge clk);
    endtask

    // extent that starts where the tail entry ends, log data contiguous too
    task automatic continue_tail(input bit [63:0] len);
        offer_extent(64'(sb.tail_fid), 64'(sb.tail_file_pos) + 64'(sb.tail_length),
                     64'(sb.tail_mem_pos) + 64'(sb.tail_length), len);
    endtask

    // wait for the block to drain and go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic configure(input bit [SHIFT_W-1:0] shift, input bit [CFG_W-1:0] cap);
        settle();
        cfg_we    = 1'b1;
        cfg_index = CFG_SLICE_SHIFT;
        cfg_data  = CFG_W'(shift);
        @(posedge clk);
        sb.set_register(CFG_SLICE_SHIFT, CFG_W'(shift));
        @(negedge clk);
        cfg_index = CFG_MAX_ENTRIES;
        cfg_data  = cap;
        @(posedge clk);
        sb.set_register(CFG_MAX_ENTRIES, cap);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly a few slices, sometimes zero, full range or too many pieces
    function automatic bit [63:0] pick_length();
        int unsigned r;
        int          sh;
        bit [63:0]   span;
        sh = int'(sb.slice_shift);
        r  = $urandom_range(0, 99);
        if (r < 5)
            return 64'd0;
        if (r < 12)
            return rand64() & LEN_MAX;
        if (r < 15)
            return ((64'd65 + 64'($urandom_range(0, 8))) << sh) & LEN_MAX;
        span = (sh >= 37) ? LEN_MAX : (64'd3 << sh) + 64'd16;
        return rand64() % (span + 1);
    endfunction

    task automatic offer_random();
        int unsigned r;
        bit [63:0]   len;
        r   = $urandom_range(0, 99);
        len = pick_length();
        if (r < 55 && sb.entry_count != 0)
            continue_tail(len);
        else if (r < 80)
            offer_extent(64'($urandom_range(0, 3)), rand64() >> $urandom_range(16, 63),
                         rand64(), len);
        else
            offer_extent(64'($urandom), rand64(), rand64(), len);
    endtask

    // main sequence
    initial
    begin
        bit [63:0] slice;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SLICE_SHIFT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        gfid      = '0;
        byte_pos  = '0;
        mem_pos   = '0;
        length    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, 1 MiB slices
        slice = 64'd1 << 20;
        offer_extent(0, 0, 0, 0);                // zero length, first entry
        continue_tail(0);                        // zero length merged
        continue_tail(100);
        continue_tail(3 * slice);                // merge then three appends
        continue_tail(slice - 100);              // ends on a slice boundary
        continue_tail(10);                       // next slice: appended
        offer_extent(1, 0, 0, 64 * slice);       // exactly the piece limit
        offer_extent(1, 0, 0, 64 * slice + 1);   // one piece too many
        offer_extent(64'h7FFF_FFFF, POS_MAX, POS_MAX, LEN_MAX);
        offer_extent(7, POS_MAX - 99, POS_MAX - 49, 3 * slice);  // positions wrap

        // capacity of zero rejects everything
        configure(SHIFT_W'(63), '0);
        offer_extent(3, 0, 0, 100);

        // merged length overflow falls back to append
        configure(SHIFT_W'(48), CFG_W'(131071));
        offer_extent(5, 0, 64'h1000, LEN_MAX);
        continue_tail(1);
        continue_tail(0);

        // table full at the capacity boundary, byte-sized slices
        configure(SHIFT_W'(0), sb.entry_count + 2'd2);
        offer_extent(9, 5, 7, 3);
        offer_extent(9, 100, 0, 1);
        offer_extent(10, 200, 0, 1);
        configure(SHIFT_W'(40), CFG_W'(1));
        offer_extent(12, 0, 0, 5);

        // slices wider than any extent length
        configure(SHIFT_W'(40), CFG_W'(65536));
        offer_extent(11, 0, 0, LEN_MAX);
        continue_tail(2);

        // random phases
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: configure(SHIFT_W'(20), CFG_W'(65536));
                1: configure(SHIFT_W'(4), CFG_W'(131071));
                2: configure(SHIFT_W'(0), CFG_W'(65536));
                3: configure(SHIFT_W'(12), sb.entry_count + CFG_W'($urandom_range(5, 40)));
                4: configure(SHIFT_W'($urandom_range(0, 63)),
                             CFG_W'($urandom_range(0, 131071)));
                5: configure(SHIFT_W'(40), CFG_W'(65536));
                6: configure(SHIFT_W'(63), CFG_W'(65536));
                default: configure(SHIFT_W'($urandom_range(0, 24)), CFG_W'(65536));
            endcase
            no_idle = (ph == 0);
            if (ph == 1)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) offer_random();
        end

        // drain and finish
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
